// ----- rtl/lcag_pkg.sv -----
// ---------------------------------------------------------------------------
// lcag_pkg
// Shared types and constants for the Life cellular automaton grid: grid size,
// command codes, controller-to-datapath command and status groups.
// ---------------------------------------------------------------------------
package lcag_pkg;

   localparam int GRID_WIDTH  = 64;
   localparam int GRID_HEIGHT = 48;

   localparam int CMD_W   = 2;
   localparam int COL_W   = 6;
   localparam int ROW_W   = 6;
   localparam int ROW_AW  = $clog2(GRID_HEIGHT);
   localparam int RADDR_W = ROW_AW + 1;
   localparam int NB_W    = 4;

   localparam int BIRTH_COUNT   = 3;
   localparam int SURVIVE_COUNT = 2;

   localparam logic [CMD_W-1:0] CMD_TOGGLE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_STEP   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   localparam logic [1:0] ADDR_REQ  = 2'd0;
   localparam logic [1:0] ADDR_CNT  = 2'd1;
   localparam logic [1:0] ADDR_CNT1 = 2'd2;
   localparam logic [1:0] ADDR_CNT2 = 2'd3;

   typedef logic [GRID_WIDTH-1:0] grid_row_type;

   typedef struct packed {
      logic       latch;
      logic       rd_en;
      logic [1:0] addr_sel;
      logic       load_cur;
      logic       load_next;
      logic       shift;
      logic       wr_gen;
      logic       wr_toggle;
      logic       cnt_clr;
      logic       cnt_inc;
      logic       rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic last_row;
   } dp_status_type;

endpackage

// ----- rtl/lcag_dp.sv -----
// ---------------------------------------------------------------------------
// lcag_dp
// Datapath: row-wide grid memory with per-row valid bits, three-row window,
// next-generation row logic, toggle logic and result register.
// ---------------------------------------------------------------------------
module lcag_dp (
   input  logic                        clock,
   input  logic                        reset,
   input  lcag_pkg::ctrl_cmd_type      cmd,
   output lcag_pkg::dp_status_type     status,
   input  logic [lcag_pkg::COL_W-1:0]  req_col,
   input  logic [lcag_pkg::ROW_W-1:0]  req_row,
   output logic                        rsp_cell_value
);

   lcag_pkg::grid_row_type mem [lcag_pkg::GRID_HEIGHT];

   logic [lcag_pkg::GRID_HEIGHT-1:0] row_valid_ff, row_valid_in;
   logic [lcag_pkg::COL_W-1:0]       col_ff;
   logic [lcag_pkg::ROW_W-1:0]       row_ff;
   logic [lcag_pkg::ROW_AW-1:0]      cnt_ff, cnt_in;
   lcag_pkg::grid_row_type           rd_data_ff;
   logic                             rd_vld_ff;
   lcag_pkg::grid_row_type           prev_ff, cur_ff, next_ff;
   logic                             cell_ff;

   logic                             in_grid;
   logic [lcag_pkg::RADDR_W-1:0]     rd_addr;
   logic                             rd_in_range;
   lcag_pkg::grid_row_type           rd_row;
   lcag_pkg::grid_row_type           new_row;
   lcag_pkg::grid_row_type           wr_data;
   logic [lcag_pkg::ROW_AW-1:0]      wr_addr;
   logic                             wr_en;

   assign in_grid = (int'(col_ff) < lcag_pkg::GRID_WIDTH)
                    && (int'(row_ff) < lcag_pkg::GRID_HEIGHT);

   always_comb begin
      unique case (cmd.addr_sel)
         lcag_pkg::ADDR_REQ:  rd_addr = lcag_pkg::RADDR_W'(row_ff);
         lcag_pkg::ADDR_CNT:  rd_addr = {1'b0, cnt_ff};
         lcag_pkg::ADDR_CNT1: rd_addr = {1'b0, cnt_ff} + lcag_pkg::RADDR_W'(1);
         lcag_pkg::ADDR_CNT2: rd_addr = {1'b0, cnt_ff} + lcag_pkg::RADDR_W'(2);
         default:             rd_addr = '0;
      endcase
      if (cmd.addr_sel == lcag_pkg::ADDR_REQ) begin
         rd_in_range = int'(row_ff) < lcag_pkg::GRID_HEIGHT;
      end else begin
         rd_in_range = int'(rd_addr) < lcag_pkg::GRID_HEIGHT;
      end
   end

   assign rd_row = rd_vld_ff ? rd_data_ff : '0;

   always_comb begin
      logic [lcag_pkg::GRID_WIDTH+1:0] p, c, n;
      logic [lcag_pkg::NB_W-1:0]       nb;
      p = {1'b0, prev_ff, 1'b0};
      c = {1'b0, cur_ff, 1'b0};
      n = {1'b0, next_ff, 1'b0};
      nb = '0;
      new_row = '0;
      for (int j = 0; j < lcag_pkg::GRID_WIDTH; j++) begin
         nb = lcag_pkg::NB_W'(p[j]) + lcag_pkg::NB_W'(p[j+1]) + lcag_pkg::NB_W'(p[j+2])
            + lcag_pkg::NB_W'(c[j]) + lcag_pkg::NB_W'(c[j+2])
            + lcag_pkg::NB_W'(n[j]) + lcag_pkg::NB_W'(n[j+1]) + lcag_pkg::NB_W'(n[j+2]);
         new_row[j] = (nb == lcag_pkg::NB_W'(lcag_pkg::BIRTH_COUNT))
                      || (c[j+1] && (nb == lcag_pkg::NB_W'(lcag_pkg::SURVIVE_COUNT)));
      end
   end

   always_comb begin
      wr_en   = cmd.wr_gen || (cmd.wr_toggle && in_grid);
      wr_addr = cmd.wr_gen ? cnt_ff : lcag_pkg::ROW_AW'(row_ff);
      wr_data = cmd.wr_gen ? new_row
                           : (rd_row ^ (lcag_pkg::grid_row_type'(1) << col_ff));
      row_valid_in = row_valid_ff;
      if (wr_en) begin
         row_valid_in[wr_addr] = 1'b1;
      end
      cnt_in = cnt_ff;
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + lcag_pkg::ROW_AW'(1);
      end
   end

   assign status.last_row = int'(cnt_ff) == lcag_pkg::GRID_HEIGHT - 1;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr[lcag_pkg::ROW_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else begin
         row_valid_ff <= row_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      if (cmd.latch) begin
         col_ff <= req_col;
         row_ff <= req_row;
      end
      if (cmd.rd_en) begin
         rd_vld_ff <= rd_in_range && row_valid_ff[rd_addr[lcag_pkg::ROW_AW-1:0]];
      end
      if (cmd.load_cur) begin
         prev_ff <= '0;
         cur_ff  <= rd_row;
      end else if (cmd.shift) begin
         prev_ff <= cur_ff;
         cur_ff  <= next_ff;
      end
      if (cmd.load_next) begin
         next_ff <= rd_row;
      end
      if (cmd.rsp_load) begin
         cell_ff <= in_grid && rd_row[col_ff];
      end
   end

   assign rsp_cell_value = cell_ff;

   a_wr_addr_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (int'(wr_addr) < lcag_pkg::GRID_HEIGHT))
      else $error("grid write beyond last row");

   a_gen_write_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_gen |=> row_valid_ff[$past(cnt_ff)])
      else $error("generation write left row invalid");

   a_off_grid_reads_dead: assert property (@(posedge clock) disable iff (reset)
      (cmd.rsp_load && !in_grid) |=> !rsp_cell_value)
      else $error("cell past the grid returned alive");

endmodule

// ----- rtl/lcag_ctrl.sv -----
// ---------------------------------------------------------------------------
// lcag_ctrl
// Controller: sequences toggle, read and generation commands over the
// datapath and owns the request/response handshakes.
// ---------------------------------------------------------------------------
module lcag_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [lcag_pkg::CMD_W-1:0]  req_cmd,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output lcag_pkg::ctrl_cmd_type      cmd,
   input  lcag_pkg::dp_status_type     status
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_TRD  = 4'd1;
   localparam logic [3:0] S_TWR  = 4'd2;
   localparam logic [3:0] S_GR0  = 4'd3;
   localparam logic [3:0] S_GR1  = 4'd4;
   localparam logic [3:0] S_GLD  = 4'd5;
   localparam logic [3:0] S_GWR  = 4'd6;
   localparam logic [3:0] S_RD   = 4'd7;
   localparam logic [3:0] S_OUT  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.latch   = 1'b1;
            cmd.cnt_clr = 1'b1;
            if (req_valid) begin
               unique case (req_cmd)
                  lcag_pkg::CMD_TOGGLE: state_in = S_TRD;
                  lcag_pkg::CMD_STEP:   state_in = S_GR0;
                  default:              state_in = S_RD;
               endcase
            end
         end
         S_TRD: begin
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = lcag_pkg::ADDR_REQ;
            state_in     = S_TWR;
         end
         S_TWR: begin
            cmd.wr_toggle = 1'b1;
            state_in      = S_RD;
         end
         S_GR0: begin
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = lcag_pkg::ADDR_CNT;
            state_in     = S_GR1;
         end
         S_GR1: begin
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = lcag_pkg::ADDR_CNT1;
            cmd.load_cur = 1'b1;
            state_in     = S_GLD;
         end
         S_GLD: begin
            cmd.load_next = 1'b1;
            state_in      = S_GWR;
         end
         S_GWR: begin
            cmd.wr_gen   = 1'b1;
            cmd.shift    = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = lcag_pkg::ADDR_CNT2;
            if (status.last_row) begin
               state_in = S_RD;
            end else begin
               cmd.cnt_inc = 1'b1;
               state_in    = S_GLD;
            end
         end
         S_RD: begin
            cmd.rd_en    = 1'b1;
            cmd.addr_sel = lcag_pkg::ADDR_REQ;
            state_in     = S_OUT;
         end
         S_OUT: begin
            if (slot_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("accepted item did not start a command");

   a_load_needs_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> slot_free)
      else $error("result overwritten before taken");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped before taken");

endmodule

// ----- rtl/life_cellular_automaton_grid.sv -----
// ---------------------------------------------------------------------------
// life_cellular_automaton_grid
// Life (B3/S23) on a grid of one-bit cells with toggle, step and read commands.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_ready  req_cmd, req_col, req_row
//   rsp_     out        rsp_valid/rsp_ready  rsp_cell_value
//
// A generation step reads the row-wide memory and writes each new row back
// row by row. Reset clears the per-row valid bits at once;
// no clearing pass. A held result sits in an output register; the next item
// is accepted meanwhile and waits only at its own result if still unread.
// ---------------------------------------------------------------------------
module life_cellular_automaton_grid (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [lcag_pkg::CMD_W-1:0]  req_cmd,
   input  logic [lcag_pkg::COL_W-1:0]  req_col,
   input  logic [lcag_pkg::ROW_W-1:0]  req_row,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_cell_value
);

   lcag_pkg::ctrl_cmd_type  cmd;
   lcag_pkg::dp_status_type status;

   lcag_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   lcag_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_col        (req_col),
      .req_row        (req_row),
      .rsp_cell_value (rsp_cell_value)
   );

endmodule
